// ===== hdl/sou_pkg.sv =====
// Shared types, constants and a lookup function for the symmetry operator unit.
`timescale 1ns / 1ps

package sou_pkg;

	// Default lattice denominator for translations
	localparam int DENOM_DEFAULT = 24;

	// Field widths
	localparam int ROT_W   = 18;
	localparam int TRANS_W = 15;
	localparam int COMP_W  = 5;
	localparam int ORDER_W = 4;

	// Action codes (code 3 is unused and yields an all-zero result)
	typedef enum logic [1:0] {
		ACT_COMPOSE = 2'd0,
		ACT_COMPARE = 2'd1,
		ACT_AXIS    = 2'd2
	} sou_action_t;

	// Status codes
	localparam logic [1:0] STAT_OK           = 2'd0;
	localparam logic [1:0] STAT_AXIS_INVALID = 2'd1;
	localparam logic [1:0] STAT_SATURATED    = 2'd2;

	// Input beat
	typedef struct packed {
		logic [1:0]         action;
		logic [ROT_W-1:0]   a_rot;
		logic [TRANS_W-1:0] a_trans;
		logic [ROT_W-1:0]   b_rot;
		logic [TRANS_W-1:0] b_trans;
	} sou_in_t;

	// Result beat
	typedef struct packed {
		logic [ROT_W-1:0]          res_rot;
		logic [TRANS_W-1:0]        res_trans;
		logic signed [ORDER_W-1:0] axis_order;
		logic                      is_equal;
		logic [1:0]                status;
	} sou_out_t;

	// Signed rotation order from determinant and trace; zero if no such rotation
	function automatic logic signed [ORDER_W-1:0] axis_lookup(
		input logic signed [7:0] det,
		input logic signed [3:0] tr
	);
		logic signed [ORDER_W-1:0] ord;
		ord = '0;
		if (det == 8'sd1) begin
			case (tr)
				-4'sd1:  ord = 4'sd2;
				4'sd0:   ord = 4'sd3;
				4'sd1:   ord = 4'sd4;
				4'sd2:   ord = 4'sd6;
				4'sd3:   ord = 4'sd1;
				default: ord = '0;
			endcase
		end else if (det == -8'sd1) begin
			case (tr)
				-4'sd3:  ord = -4'sd1;
				-4'sd2:  ord = -4'sd6;
				-4'sd1:  ord = -4'sd4;
				4'sd0:   ord = -4'sd3;
				4'sd1:   ord = -4'sd2;
				default: ord = '0;
			endcase
		end
		return ord;
	endfunction

endpackage

// ===== hdl/sou_mod_reduce.sv =====
// Reduces a small signed value into 0..DENOM-1 by reciprocal multiply and one correction.
`timescale 1ns / 1ps

module sou_mod_reduce #(
	parameter int DENOM = sou_pkg::DENOM_DEFAULT
) (
	input  logic signed [8:0]              val,
	output logic [sou_pkg::COMP_W-1:0]     rem
);
	import sou_pkg::*;

	// Offset is a multiple of DENOM that lifts the most negative input to zero or above
	localparam int NEG_SPAN = 186;
	localparam int OFFSET   = ((NEG_SPAN + DENOM - 1) / DENOM) * DENOM;
	localparam int RECIP    = (1 << 16) / DENOM;

	logic [9:0]  u;
	logic [25:0] prod;
	logic [9:0]  quo;
	logic [9:0]  qd;
	logic [9:0]  r;
	logic [9:0]  rr;

	// Biased value, never negative and below 1024
	assign u = {val[8], val} + 10'(OFFSET);

	// Quotient estimate is exact or one short
	assign prod = 26'(u) * 26'(RECIP);
	assign quo  = prod[25:16];
	assign qd   = 10'(15'(quo) * 15'(DENOM));
	assign r    = u - qd;

	// One conditional subtract finishes the reduction
	assign rr  = (r >= 10'(DENOM)) ? r - 10'(DENOM) : r;
	assign rem = rr[COMP_W-1:0];

endmodule

// ===== hdl/sou_core.sv =====
// Single-pass datapath: compose, compare and axis order classification.
`timescale 1ns / 1ps

module sou_core #(
	parameter int DENOM = sou_pkg::DENOM_DEFAULT
) (
	input  sou_pkg::sou_in_t  op,
	output sou_pkg::sou_out_t res
);
	import sou_pkg::*;

	logic signed [1:0]        ra [9];
	logic signed [1:0]        rb [9];
	logic [COMP_W-1:0]        ta [3];
	logic [COMP_W-1:0]        tb [3];
	logic signed [4:0]        prod_sum [9];
	logic [1:0]               sat_code [9];
	logic [8:0]               sat_flag;
	logic signed [8:0]        tsum [3];
	logic signed [8:0]        red_in [3];
	logic [COMP_W-1:0]        red_out [3];
	logic signed [7:0]        det;
	logic signed [3:0]        tr;
	logic signed [ORDER_W-1:0] order;
	logic                     rot_match;
	logic                     trans_match;

	// Unpack entries and components
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			ra[k] = op.a_rot[2*k +: 2];
			rb[k] = op.b_rot[2*k +: 2];
		end
		for (int i = 0; i < 3; i++) begin
			ta[i] = op.a_trans[COMP_W*i +: COMP_W];
			tb[i] = op.b_trans[COMP_W*i +: COMP_W];
		end
	end

	// Rotation product with saturation to -1..1
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				prod_sum[i*3+j] = 5'(ra[i*3+0]) * 5'(rb[0*3+j])
					+ 5'(ra[i*3+1]) * 5'(rb[1*3+j])
					+ 5'(ra[i*3+2]) * 5'(rb[2*3+j]);
				if (prod_sum[i*3+j] > 5'sd1) begin
					sat_code[i*3+j] = 2'b01;
					sat_flag[i*3+j] = 1'b1;
				end else if (prod_sum[i*3+j] < -5'sd1) begin
					sat_code[i*3+j] = 2'b11;
					sat_flag[i*3+j] = 1'b1;
				end else begin
					sat_code[i*3+j] = prod_sum[i*3+j][1:0];
					sat_flag[i*3+j] = 1'b0;
				end
			end
		end
	end

	// Translation Ra*tb + ta, unreduced; unsaturated Ra is used
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tsum[i] = $signed({4'b0, ta[i]})
				+ 9'(ra[i*3+0]) * $signed({4'b0, tb[0]})
				+ 9'(ra[i*3+1]) * $signed({4'b0, tb[1]})
				+ 9'(ra[i*3+2]) * $signed({4'b0, tb[2]});
		end
	end

	// Reducers are shared: compose feeds the sums, compare feeds ta - tb
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (op.action == ACT_COMPARE)
				red_in[i] = $signed({4'b0, ta[i]}) - $signed({4'b0, tb[i]});
			else
				red_in[i] = tsum[i];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_red
		sou_mod_reduce #(
			.DENOM(DENOM)
		) u_red (
			.val(red_in[g]),
			.rem(red_out[g])
		);
	end

	// Determinant and trace of Ra
	always_comb begin
		det = 8'(ra[0]) * (8'(ra[4]) * 8'(ra[8]) - 8'(ra[5]) * 8'(ra[7]))
			- 8'(ra[1]) * (8'(ra[3]) * 8'(ra[8]) - 8'(ra[5]) * 8'(ra[6]))
			+ 8'(ra[2]) * (8'(ra[3]) * 8'(ra[7]) - 8'(ra[4]) * 8'(ra[6]));
		tr = 4'(ra[0]) + 4'(ra[4]) + 4'(ra[8]);
	end

	assign order       = axis_lookup(det, tr);
	assign rot_match   = (op.a_rot == op.b_rot);
	assign trans_match = (red_out[0] == '0) && (red_out[1] == '0) && (red_out[2] == '0);

	// Result select by action
	always_comb begin
		res = '0;
		unique case (op.action)
			ACT_COMPOSE: begin
				for (int k = 0; k < 9; k++)
					res.res_rot[2*k +: 2] = sat_code[k];
				for (int i = 0; i < 3; i++)
					res.res_trans[COMP_W*i +: COMP_W] = red_out[i];
				res.status = (|sat_flag) ? STAT_SATURATED : STAT_OK;
			end
			ACT_COMPARE: begin
				res.is_equal = rot_match && trans_match;
			end
			ACT_AXIS: begin
				res.axis_order = order;
				res.status     = (order == '0) ? STAT_AXIS_INVALID : STAT_OK;
			end
			default: res = '0;
		endcase
	end

endmodule

// ===== hdl/symmetry_operator_unit.sv =====
// Top level: input register, single-pass datapath, result register with handshakes.
`timescale 1ns / 1ps

// Symmetry operator unit. Each op beat carries two Seitz operators and an action
// (compose, compare, or axis order of A); each op beat yields exactly one res beat.
// Throughput is one beat per cycle while results drain; each beat is registered in the
// input register and the result register around one combinational pass. A stalled result
// holds the result register and, once the input register is also full, op_ready drops.
// DENOM sets the translation period (2..31); components are 5-bit fields.
module symmetry_operator_unit #(
	parameter int DENOM = sou_pkg::DENOM_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  sou_pkg::sou_in_t  op,
	output logic              res_valid,
	input  logic              res_ready,
	output sou_pkg::sou_out_t res
);
	import sou_pkg::*;

	sou_in_t  op_s1;
	logic     valid_s1;
	sou_out_t core_res;
	sou_out_t res_q;
	logic     res_valid_q;
	logic     adv;

	// Result register may load when empty or being drained
	assign adv      = !res_valid_q || res_ready;
	assign op_ready = !valid_s1 || adv;

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			op_s1 <= op;
		end
	end

	sou_core #(
		.DENOM(DENOM)
	) u_core (
		.op (op_s1),
		.res(core_res)
	);

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s1;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_q <= core_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// An accepted beat lands in the input stage
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		op_valid && op_ready |=> valid_s1)
		else $error("accepted beat missing from input stage");

	// A full input stage is not dropped while the result stage stalls
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(op_s1))
		else $error("input stage lost during stall");

	// Equality is reported only with an otherwise empty, clean result
	a_equal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.is_equal |->
			res_q.res_rot == '0 && res_q.status == STAT_OK && res_q.axis_order == '0)
		else $error("compare result carries other fields");

	// Saturation comes from compose only, so no axis order or equality with it
	a_sat_compose: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status == STAT_SATURATED |->
			res_q.axis_order == '0 && !res_q.is_equal)
		else $error("saturation status outside compose");

endmodule

// ===== tb/sv/sou_result_checker.sv =====
// Result checker for the symmetry operator unit: predicts each op beat and compares res beats.
`timescale 1ns / 1ps

module sou_result_checker #(
	parameter int DENOM = sou_pkg::DENOM_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  logic              op_ready,
	input  sou_pkg::sou_in_t  op,
	input  logic              res_valid,
	input  logic              res_ready,
	input  sou_pkg::sou_out_t res,
	output int                errors,
	output int                pending,
	output int                checked,
	output int                n_saturated,
	output int                n_axis_invalid,
	output int                n_equal
);
	import sou_pkg::*;

	// Predicted res beats, oldest first
	sou_out_t expected_results[$];

	initial begin
		errors = 0;
		pending = 0;
		checked = 0;
		n_saturated = 0;
		n_axis_invalid = 0;
		n_equal = 0;
	end

	task automatic flag(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// 2-bit two's complement rotation entry k
	function automatic int rot_elem(input logic [ROT_W-1:0] p, input int k);
		return $signed(p[2*k +: 2]);
	endfunction

	function automatic int trans_comp(input logic [TRANS_W-1:0] p, input int i);
		return int'(p[COMP_W*i +: COMP_W]);
	endfunction

	// Reduce into 0..DENOM-1, also for negative sums
	function automatic int wrap_period(input int v);
		int r;
		r = v % DENOM;
		if (r < 0)
			r += DENOM;
		return r;
	endfunction

	// Signed order from determinant and trace; zero when no point-group rotation matches
	function automatic logic signed [ORDER_W-1:0] classify_rotation(input int m[9]);
		int det;
		int tr;
		int ord;
		det = m[0] * (m[4] * m[8] - m[5] * m[7])
			- m[1] * (m[3] * m[8] - m[5] * m[6])
			+ m[2] * (m[3] * m[7] - m[4] * m[6]);
		tr = m[0] + m[4] + m[8];
		ord = 0;
		if (det == -1) begin
			case (tr)
				-3: ord = -1;
				-2: ord = -6;
				-1: ord = -4;
				0:  ord = -3;
				1:  ord = -2;
				default: ord = 0;
			endcase
		end else if (det == 1) begin
			case (tr)
				-1: ord = 2;
				0:  ord = 3;
				1:  ord = 4;
				2:  ord = 6;
				3:  ord = 1;
				default: ord = 0;
			endcase
		end
		return ord[ORDER_W-1:0];
	endfunction

	// Expected res beat for one op beat
	function automatic sou_out_t seitz_result(input sou_in_t x);
		sou_out_t r;
		int ra[9];
		int rb[9];
		int s;
		int t;
		int w;
		bit same;
		r = '0;
		for (int k = 0; k < 9; k++) begin
			ra[k] = rot_elem(x.a_rot, k);
			rb[k] = rot_elem(x.b_rot, k);
		end
		case (x.action)
			ACT_COMPOSE: begin
				for (int i = 0; i < 3; i++) begin
					t = trans_comp(x.a_trans, i);
					for (int j = 0; j < 3; j++) begin
						s = 0;
						for (int k = 0; k < 3; k++)
							s += ra[i*3+k] * rb[k*3+j];
						// clamp product entry, translation keeps raw Ra
						if (s > 1) begin
							s = 1;
							r.status = STAT_SATURATED;
						end
						if (s < -1) begin
							s = -1;
							r.status = STAT_SATURATED;
						end
						r.res_rot[2*(i*3+j) +: 2] = s[1:0];
						t += ra[i*3+j] * trans_comp(x.b_trans, j);
					end
					w = wrap_period(t);
					r.res_trans[COMP_W*i +: COMP_W] = w[COMP_W-1:0];
				end
			end
			ACT_COMPARE: begin
				same = (x.a_rot == x.b_rot);
				for (int i = 0; i < 3; i++)
					if (wrap_period(trans_comp(x.a_trans, i) - trans_comp(x.b_trans, i)) != 0)
						same = 1'b0;
				r.is_equal = same;
			end
			ACT_AXIS: begin
				r.axis_order = classify_rotation(ra);
				if (r.axis_order == '0)
					r.status = STAT_AXIS_INVALID;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Compare accepted res beats, then queue the prediction for an accepted op beat
	always @(posedge clk) begin : watch
		sou_out_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					flag($sformatf("res beat %0d with no op beat outstanding", checked));
				end else begin
					want = expected_results.pop_front();
					if (res.res_rot !== want.res_rot)
						flag($sformatf("res %0d res_rot got %05h want %05h",
							checked, res.res_rot, want.res_rot));
					if (res.res_trans !== want.res_trans)
						flag($sformatf("res %0d res_trans got %04h want %04h",
							checked, res.res_trans, want.res_trans));
					if (res.axis_order !== want.axis_order)
						flag($sformatf("res %0d axis_order got %0d want %0d",
							checked, res.axis_order, want.axis_order));
					if (res.is_equal !== want.is_equal)
						flag($sformatf("res %0d is_equal got %b want %b",
							checked, res.is_equal, want.is_equal));
					if (res.status !== want.status)
						flag($sformatf("res %0d status got %0d want %0d",
							checked, res.status, want.status));
					if (want.status == STAT_SATURATED)
						n_saturated++;
					if (want.status == STAT_AXIS_INVALID)
						n_axis_invalid++;
					if (want.is_equal)
						n_equal++;
					checked++;
				end
			end
			if (op_valid && op_ready)
				expected_results.push_back(seitz_result(op));
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_symmetry_operator_unit.sv =====
// Testbench top for the symmetry operator unit: clock, reset, stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module tb_symmetry_operator_unit;
	import sou_pkg::*;

	localparam int LAT_DENOM = DENOM_DEFAULT;
	localparam int RANDOM_BEATS = 800;
	localparam int CALM_TAIL = 120;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AFTER = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic     clk;
	logic     arst_n;
	logic     op_valid;
	logic     op_ready;
	sou_in_t  op;
	logic     res_valid;
	logic     res_ready;
	sou_out_t res;

	int errors;
	int pending;
	int checked;
	int n_saturated;
	int n_axis_invalid;
	int n_equal;
	int sent = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit held_long = 1'b0;

	symmetry_operator_unit #(.DENOM(LAT_DENOM)) dut (
		.clk,
		.arst_n,
		.op_valid,
		.op_ready,
		.op,
		.res_valid,
		.res_ready,
		.res
	);

	sou_result_checker #(.DENOM(LAT_DENOM)) u_check (
		.clk,
		.arst_n,
		.op_valid,
		.op_ready,
		.op,
		.res_valid,
		.res_ready,
		.res,
		.errors,
		.pending,
		.checked,
		.n_saturated,
		.n_axis_invalid,
		.n_equal
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Row-major entries, e0 lands in the low bits
	function automatic logic [ROT_W-1:0] rot_of(input int e0, e1, e2, e3, e4, e5, e6, e7, e8);
		return {2'(e8), 2'(e7), 2'(e6), 2'(e5), 2'(e4), 2'(e3), 2'(e2), 2'(e1), 2'(e0)};
	endfunction

	function automatic logic [TRANS_W-1:0] trans_of(input int x, y, z);
		return {5'(z), 5'(y), 5'(x)};
	endfunction

	function automatic logic [ROT_W-1:0] neg_rot(input logic [ROT_W-1:0] v);
		logic [ROT_W-1:0] w;
		int e;
		for (int k = 0; k < 9; k++) begin
			e = $signed(v[2*k +: 2]);
			e = -e;
			w[2*k +: 2] = e[1:0];
		end
		return w;
	endfunction

	// Random element of the cubic group: signed permutation matrix
	function automatic logic [ROT_W-1:0] signed_perm();
		int col[3];
		int m[9];
		int p;
		logic [ROT_W-1:0] v;
		p = $urandom_range(0, 5);
		col[0] = p % 3;
		col[1] = (col[0] + 1 + p / 3) % 3;
		col[2] = 3 - col[0] - col[1];
		for (int k = 0; k < 9; k++)
			m[k] = 0;
		for (int r = 0; r < 3; r++)
			m[r*3 + col[r]] = $urandom_range(0, 1) ? 1 : -1;
		for (int k = 0; k < 9; k++)
			v[2*k +: 2] = m[k][1:0];
		return v;
	endfunction

	// Hexagonal 3- and 6-fold rotations about z, proper or improper
	function automatic logic [ROT_W-1:0] hex_rot();
		logic [ROT_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = rot_of(1, -1, 0, 1, 0, 0, 0, 0, 1);
			1: v = rot_of(0, -1, 0, 1, -1, 0, 0, 0, 1);
			2: v = rot_of(0, 1, 0, -1, 1, 0, 0, 0, 1);
			default: v = rot_of(-1, 1, 0, -1, 0, 0, 0, 0, 1);
		endcase
		if ($urandom_range(0, 1))
			v = neg_rot(v);
		return v;
	endfunction

	// Mostly well-formed rotations, some raw bit patterns (includes the -2 code)
	function automatic logic [ROT_W-1:0] any_rot();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3)
			return ROT_W'($urandom);
		else if (pick < 7)
			return signed_perm();
		else
			return hex_rot();
	endfunction

	function automatic logic [TRANS_W-1:0] rand_trans();
		if ($urandom_range(0, 2) == 0)
			return TRANS_W'($urandom);
		return trans_of($urandom_range(0, LAT_DENOM - 1), $urandom_range(0, LAT_DENOM - 1),
			$urandom_range(0, LAT_DENOM - 1));
	endfunction

	// Same translation up to whole lattice periods, where the 5-bit field allows
	function automatic logic [TRANS_W-1:0] shift_period(input logic [TRANS_W-1:0] t);
		logic [TRANS_W-1:0] w;
		int c;
		for (int i = 0; i < 3; i++) begin
			c = int'(t[COMP_W*i +: COMP_W]);
			if (c + LAT_DENOM <= 31 && $urandom_range(0, 1))
				c += LAT_DENOM;
			else if (c >= LAT_DENOM && $urandom_range(0, 1))
				c -= LAT_DENOM;
			w[COMP_W*i +: COMP_W] = c[COMP_W-1:0];
		end
		return w;
	endfunction

	function automatic sou_in_t make_beat(input logic [1:0] act,
		input logic [ROT_W-1:0] ar, input logic [TRANS_W-1:0] at,
		input logic [ROT_W-1:0] br, input logic [TRANS_W-1:0] bt);
		sou_in_t b;
		b.action = act;
		b.a_rot = ar;
		b.a_trans = at;
		b.b_rot = br;
		b.b_trans = bt;
		return b;
	endfunction

	function automatic sou_in_t random_beat();
		sou_in_t b;
		int pick;
		pick = $urandom_range(0, 19);
		b.a_rot = any_rot();
		b.b_rot = any_rot();
		b.a_trans = rand_trans();
		b.b_trans = rand_trans();
		if (pick < 8) begin
			b.action = ACT_COMPOSE;
		end else if (pick < 13) begin
			b.action = ACT_COMPARE;
			// matching pairs, pairs off by one bit, and unrelated pairs
			case ($urandom_range(0, 4))
				0, 1: begin
					b.b_rot = b.a_rot;
					b.b_trans = shift_period(b.a_trans);
				end
				2: begin
					b.b_rot = b.a_rot ^ (ROT_W'(1) << $urandom_range(0, ROT_W - 1));
					b.b_trans = shift_period(b.a_trans);
				end
				3: begin
					b.b_rot = b.a_rot;
					b.b_trans = shift_period(b.a_trans)
						^ (TRANS_W'(1) << $urandom_range(0, TRANS_W - 1));
				end
				default: ;
			endcase
		end else if (pick < 19) begin
			b.action = ACT_AXIS;
		end else begin
			b.action = ACT_UNUSED;
		end
		return b;
	endfunction

	// Offer one op beat, optionally after an idle burst; returns once it is taken
	task automatic send_beat(input sou_in_t x);
		int gap;
		gap = 0;
		if (!calm && (sent / 40) % 3 != 2 && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			op_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= x;
		op_valid <= 1'b1;
		do @(posedge clk); while (!op_ready);
		sent++;
	endtask

	// Stimulus: directed corners, then random beats, then drain and verdict
	initial begin : stimulus
		logic [ROT_W-1:0] ident;
		logic [ROT_W-1:0] axis_set[12];
		arst_n <= 1'b0;
		op_valid <= 1'b0;
		op <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ident = rot_of(1, 0, 0, 0, 1, 0, 0, 0, 1);

		// compose: identity, all -2 with widest translations, all +1, all -1
		send_beat(make_beat(ACT_COMPOSE, ident, trans_of(0, 0, 0), ident, trans_of(0, 0, 0)));
		send_beat(make_beat(ACT_COMPOSE, {9{2'b10}}, '1, {9{2'b10}}, '1));
		send_beat(make_beat(ACT_COMPOSE, {9{2'b01}}, trans_of(23, 23, 23), {9{2'b01}}, '1));
		send_beat(make_beat(ACT_COMPOSE, '1, trans_of(0, 0, 0), ident, '1));

		// compare: identical, equal modulo a period, rotation differs, translation differs
		send_beat(make_beat(ACT_COMPARE, rot_of(1, -1, 0, 1, 0, 0, 0, 0, 1),
			trans_of(5, 17, 23), rot_of(1, -1, 0, 1, 0, 0, 0, 0, 1), trans_of(5, 17, 23)));
		send_beat(make_beat(ACT_COMPARE, ident, trans_of(31, 30, 24), ident,
			trans_of(7, 6, 0)));
		send_beat(make_beat(ACT_COMPARE, ident, trans_of(3, 3, 3),
			rot_of(1, 0, 0, 0, 1, 0, 0, 0, -1), trans_of(3, 3, 3)));
		send_beat(make_beat(ACT_COMPARE, ident, trans_of(0, 0, 1), ident, trans_of(0, 0, 0)));

		// axis order: every row of the det/trace table, then two invalid matrices
		axis_set[0] = rot_of(1, 0, 0, 0, 1, 0, 0, 0, 1);
		axis_set[1] = rot_of(-1, 0, 0, 0, -1, 0, 0, 0, -1);
		axis_set[2] = rot_of(1, 0, 0, 0, -1, 0, 0, 0, -1);
		axis_set[3] = rot_of(-1, 0, 0, 0, 1, 0, 0, 0, 1);
		axis_set[4] = rot_of(0, 0, 1, 1, 0, 0, 0, 1, 0);
		axis_set[5] = rot_of(0, 0, -1, -1, 0, 0, 0, -1, 0);
		axis_set[6] = rot_of(0, -1, 0, 1, 0, 0, 0, 0, 1);
		axis_set[7] = rot_of(0, 1, 0, -1, 0, 0, 0, 0, -1);
		axis_set[8] = rot_of(1, -1, 0, 1, 0, 0, 0, 0, 1);
		axis_set[9] = rot_of(-1, 1, 0, -1, 0, 0, 0, 0, -1);
		axis_set[10] = '0;
		axis_set[11] = rot_of(-2, 0, 0, 0, 1, 0, 0, 0, 1);
		for (int n = 0; n < 12; n++)
			send_beat(make_beat(ACT_AXIS, axis_set[n], rand_trans(), ROT_W'($urandom),
				rand_trans()));

		// unused action code
		send_beat(make_beat(ACT_UNUSED, '1, '1, '1, '1));

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n == RANDOM_BEATS - CALM_TAIL)
				calm = 1'b1;
			send_beat(random_beat());
		end
		op_valid <= 1'b0;

		// sample away from the driving edge so the checker has updated
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d op beats: directed corners of every action, then random mixes.",
			sent);
		$display("Checked %0d results: %0d saturated, %0d invalid axis, %0d equal pairs.",
			checked, n_saturated, n_axis_invalid, n_equal);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Result side: random stall bursts, one long hold-off to back up the input
	initial begin : sink
		int hold;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held_long && sent >= HOLD_AFTER) begin
				held_long = 1'b1;
				res_ready <= 1'b0;
				hold = 0;
				while (hold < LONG_HOLD) begin
					@(posedge clk);
					hold++;
				end
			end else if (!calm && (cycles / 200) % 3 != 0 && $urandom_range(0, 7) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
